/* hw/rtl/boxf_pkg.sv */
// Shared types, constants and the divide-by-nine helper of the 3x3 box filter.
`timescale 1ns / 1ps

package boxf_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int CFG_W      = 12;
    localparam int SUM_W      = 12;
    localparam int MIN_SIZE   = 3;
    localparam int MAX_HEIGHT = 2048;
    localparam int DIV9_MUL   = 7282;
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W     = 25;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]   mean_value;
        logic [COORD_W-1:0] center_column;
        logic [COORD_W-1:0] center_row;
        logic               frame_last;
    } mean_out_t;

    // Truncated sum / 9 by reciprocal multiply; exact for any sum of nine 8-bit pixels (up to 2295).
    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

/* hw/rtl/box_filter_3x3_mean.sv */
// Top level of the streaming 3x3 box (mean) filter for 8-bit grayscale pixels.
`timescale 1ns / 1ps

// Channel   Dir   Ports                          Beat
// --------  ----  -----------------------------  -----------------------------------
// s_        in    s_valid s_ready s_data         one pixel + frame start flag
// m_        out   m_valid m_ready m_data         mean, center column/row, frame last
// cfg_      in    cfg_wr_en cfg_index cfg_wr_data  frame_width (0), frame_height (1)
//
// Takes one pixel per cycle while the output is not stalled; a result passes the input
// stage (with line store read), then the output register.
// Throughput is set by the single line store read port: one read and one write a cycle.
// Reset (aresetn low, synchronous) empties both stages and zeroes counters and window;
// the line store is not cleared, rows 0 and 1 of a frame fill it before it is used.
// A stalled result holds the whole pipe; s_ready drops only while m_ already holds a beat
// that is not taken.

module box_filter_3x3_mean #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // pixel stream
    input  logic                       s_valid,
    output logic                       s_ready,
    input  boxf_pkg::pix_in_t          s_data,
    // filtered stream
    output logic                       m_valid,
    input  logic                       m_ready,
    output boxf_pkg::mean_out_t        m_data,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [boxf_pkg::CFG_W-1:0] cfg_wr_data
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (XW + 1 > boxf_pkg::CFG_W) ? XW + 1 : boxf_pkg::CFG_W;
    localparam int PW   = boxf_pkg::PIX_W;
    localparam int YW   = boxf_pkg::COORD_W;
    localparam int SW   = boxf_pkg::SUM_W;
    localparam int HW   = boxf_pkg::CFG_W;

    // ---------------- configuration ----------------
    logic [HW-1:0] frame_width_reg;
    logic [HW-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= HW'(640);
            frame_height_reg <= HW'(480);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                boxf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                boxf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Saturate the frame size into the supported range.
    logic [CMPW-1:0] w_raw;
    logic [CMPW-1:0] w_clamp;
    logic [CMPW-1:0] w_m1;
    logic [HW-1:0]   h_clamp;
    logic [HW-1:0]   h_m1;

    always_comb begin
        w_raw = CMPW'(frame_width_reg);
        if (w_raw < CMPW'(boxf_pkg::MIN_SIZE)) begin
            w_clamp = CMPW'(boxf_pkg::MIN_SIZE);
        end else if (w_raw > CMPW'(MAX_WIDTH)) begin
            w_clamp = CMPW'(MAX_WIDTH);
        end else begin
            w_clamp = w_raw;
        end
        if (frame_height_reg < HW'(boxf_pkg::MIN_SIZE)) begin
            h_clamp = HW'(boxf_pkg::MIN_SIZE);
        end else if (frame_height_reg > HW'(boxf_pkg::MAX_HEIGHT)) begin
            h_clamp = HW'(boxf_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = frame_height_reg;
        end
        w_m1 = w_clamp - CMPW'(1);
        h_m1 = h_clamp - HW'(1);
    end

    // ---------------- pipeline control ----------------
    logic m_valid_reg;
    logic advance;
    logic s_fire;

    // The pipe moves whenever the output register is empty or being drained.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign s_fire  = s_valid && advance;

    // ---------------- position counters (input side) ----------------
    logic [XW-1:0] column_count_reg, column_count_next;
    logic [YW-1:0] row_count_reg, row_count_next;
    logic [XW-1:0] x_cur;
    logic [YW-1:0] y_cur;
    logic          col_last;
    logic          row_last;

    always_comb begin
        // Frame start forces this beat to column 0, row 0.
        x_cur    = s_data.frame_start ? '0 : column_count_reg;
        y_cur    = s_data.frame_start ? '0 : row_count_reg;
        col_last = CMPW'(x_cur) >= w_m1;
        row_last = HW'(y_cur) >= h_m1;
        if (col_last) begin
            column_count_next = '0;
            row_count_next    = row_last ? '0 : y_cur + YW'(1);
        end else begin
            column_count_next = x_cur + XW'(1);
            row_count_next    = y_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (s_fire) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ---------------- stage 1: accepted pixel + line store read ----------------
    logic            st1_valid_reg;
    logic [PW-1:0]   st1_pix_reg;
    logic [XW-1:0]   st1_x_reg;
    logic [YW-1:0]   st1_y_reg;
    logic            st1_emit_reg;
    logic            st1_last_reg;
    logic            st1_fwd_reg;
    logic [2*PW-1:0] st1_fwd_data_reg;

    logic            ram_we;
    logic [2*PW-1:0] ram_wdata;
    logic [2*PW-1:0] ram_rdata;
    logic [2*PW-1:0] lines;
    logic [PW-1:0]   top;
    logic [PW-1:0]   mid;
    logic            fwd_hit;

    // Line store word: upper byte is two rows up, lower byte is one row up.
    boxf_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (st1_x_reg),
        .wr_data (ram_wdata),
        .rd_en   (s_fire),
        .rd_addr (x_cur),
        .rd_data (ram_rdata)
    );

    // Stage 1 writes back as it leaves; a read of the same column in that very
    // cycle (back-to-back frame starts) would see the old word, so forward it.
    assign ram_we    = advance && st1_valid_reg;
    assign fwd_hit   = ram_we && (st1_x_reg == x_cur);
    assign lines     = st1_fwd_reg ? st1_fwd_data_reg : ram_rdata;
    assign top       = lines[2*PW-1:PW];
    assign mid       = lines[PW-1:0];
    assign ram_wdata = {mid, st1_pix_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (advance) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_pix_reg      <= s_data.pixel_in;
            st1_x_reg        <= x_cur;
            st1_y_reg        <= y_cur;
            st1_emit_reg     <= (x_cur >= XW'(2)) && (y_cur >= YW'(2));
            st1_last_reg     <= col_last && row_last;
            st1_fwd_reg      <= fwd_hit;
            st1_fwd_data_reg <= ram_wdata;
        end
    end

    // ---------------- window and mean ----------------
    logic [PW-1:0] window_reg [6];
    logic [SW-1:0] win_sum;
    logic [PW-1:0] mean_next;

    // Adder tree over the nine window pixels, then the reciprocal multiply.
    always_comb begin
        win_sum = (SW'(top) + SW'(mid) + SW'(st1_pix_reg))
                + (SW'(window_reg[0]) + SW'(window_reg[1]) + SW'(window_reg[2]))
                + (SW'(window_reg[3]) + SW'(window_reg[4]) + SW'(window_reg[5]));
        mean_next = boxf_pkg::div9(win_sum);
    end

    // Shift the window one column left as each beat leaves stage 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                window_reg[i] <= '0;
            end
        end else if (ram_we) begin
            window_reg[0] <= window_reg[3];
            window_reg[1] <= window_reg[4];
            window_reg[2] <= window_reg[5];
            window_reg[3] <= top;
            window_reg[4] <= mid;
            window_reg[5] <= st1_pix_reg;
        end
    end

    // ---------------- output register ----------------
    boxf_pkg::mean_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= st1_valid_reg && st1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we && st1_emit_reg) begin
            m_data_reg.mean_value    <= mean_next;
            m_data_reg.center_column <= YW'(XW'(st1_x_reg - XW'(1)));
            m_data_reg.center_row    <= st1_y_reg - YW'(1);
            m_data_reg.frame_last    <= st1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    a_column_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(column_count_reg) <= CMPW'(MAX_WIDTH - 1))
        else $error("column counter beyond line store depth");

    a_write_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> st1_valid_reg && (!m_valid || m_ready))
        else $error("line store written without stage 1 advancing");

    a_result_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(st1_valid_reg) && $past(st1_emit_reg))
        else $error("result produced without an interior pixel in stage 1");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !st1_valid_reg)
        else $error("pipeline not empty after reset");

endmodule

/* hw/rtl/boxf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module boxf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
